>>> src/nsmf_pkg.sv
// ----------------------------------------------------------------------------
// Next scheduled minute finder package
// Shared constants, the sequencer state type and search helper functions.
// ----------------------------------------------------------------------------
package nsmf_pkg;

  // Schedule geometry.
  localparam int HOURS   = 24;
  localparam int MINUTES = 60;
  localparam int DAYS    = 7;

  // Field widths.
  localparam int HOUR_W = 5;
  localparam int MIN_W  = 6;
  localparam int DAY_W  = 3;
  localparam int WDAY_W = 3;
  localparam int MASK_W = 7;

  // Item kinds.
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_PUT
  } state_t;

  // Result of a minute search within one hour word.
  typedef struct packed {
    logic             hit;
    logic [MIN_W-1:0] minute;
  } minute_hit_t;

  // Result of the search for the first allowed day ahead.
  typedef struct packed {
    logic             ok;
    logic [DAY_W-1:0] offset;
  } day_hit_t;

  // Lowest set bit of an hour word, found by isolating it and encoding.
  function automatic minute_hit_t first_minute(input logic [MINUTES-1:0] word);
    logic [MINUTES-1:0] low;
    minute_hit_t        res;
    low        = word & (~word + {{(MINUTES-1){1'b0}}, 1'b1});
    res.hit    = |word;
    res.minute = '0;
    for (int i = 0; i < MINUTES; i++) begin
      if (low[i]) begin
        res.minute = res.minute | MIN_W'(i);
      end
    end
    return res;
  endfunction

  // Remainder by seven of a sum that stays below fifteen.
  function automatic logic [WDAY_W-1:0] mod7(input logic [3:0] s);
    logic [3:0] r;
    if (s >= 4'd14) begin
      r = s - 4'd14;
    end else if (s >= 4'd7) begin
      r = s - 4'd7;
    end else begin
      r = s;
    end
    return r[WDAY_W-1:0];
  endfunction

  // First offset of one to seven days whose weekday the mask allows.
  function automatic day_hit_t first_day(input logic [WDAY_W-1:0] wday,
                                         input logic [MASK_W-1:0] mask);
    day_hit_t          res;
    logic [WDAY_W-1:0] d;
    res.ok     = 1'b0;
    res.offset = '0;
    for (int k = DAYS; k >= 1; k--) begin
      d = mod7({1'b0, wday} + 4'(k));
      if (mask[d]) begin
        res.ok     = 1'b1;
        res.offset = DAY_W'(k);
      end
    end
    return res;
  endfunction

endpackage

>>> src/nsmf_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module nsmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wen,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             ren,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/next_scheduled_minute_finder_core.sv
// ----------------------------------------------------------------------------
// Next scheduled minute finder core
// Keeps 24 hour words of start minutes and answers next-start queries.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+-----------------------------------
//  in      | input     | in_valid/in_stall  | kind, hour_index, minute_bits,
//          |           |                    | now_weekday, now_minute, day_mask,
//          |           |                    | schedule_enabled
//  out     | output    | out_valid/out_stall| found, day_offset, start_hour,
//          |           |                    | start_minute
//
//  A load beat or an immediate answer goes from accept through S_PUT to the
//  output register. A query reads one hour word from the store per S_READ and
//  S_EVAL pass: up to 24 - hour words for today plus up to 24 for the days
//  ahead. Reset clears the hour valid bits at once, so no clearing pass is
//  needed. A new beat is taken while the previous result waits in the output
//  register.
//
module next_scheduled_minute_finder_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        kind,
  input  logic [nsmf_pkg::HOUR_W-1:0]  hour_index,
  input  logic [nsmf_pkg::MINUTES-1:0] minute_bits,
  input  logic [nsmf_pkg::WDAY_W-1:0]  now_weekday,
  input  logic [nsmf_pkg::MIN_W-1:0]   now_minute,
  input  logic [nsmf_pkg::MASK_W-1:0]  day_mask,
  input  logic                        schedule_enabled,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        found,
  output logic [nsmf_pkg::DAY_W-1:0]   day_offset,
  output logic [nsmf_pkg::HOUR_W-1:0]  start_hour,
  output logic [nsmf_pkg::MIN_W-1:0]   start_minute
);

  import nsmf_pkg::*;

  localparam logic [HOUR_W-1:0]  LAST_HOUR = HOUR_W'(HOURS - 1);
  localparam logic [MINUTES-1:0] ALL_MIN   = {MINUTES{1'b1}};

  state_t state, state_next;

  logic               accept;
  logic               today_ok;
  day_hit_t           ahead_in;
  logic               out_free;
  logic               out_load;
  logic               ram_wen;
  logic               ram_ren;
  logic [MINUTES-1:0] ram_rdata;
  logic [HOURS-1:0]   hour_valid;
  logic               rd_vld;
  logic [MINUTES-1:0] word;
  minute_hit_t        hit;

  // Search context.
  logic [HOUR_W-1:0]  cnt;
  logic [MIN_W-1:0]   from_min;
  logic               today_phase;
  logic               ahead_ok;
  logic [DAY_W-1:0]   ahead_off;

  // Pending result.
  logic               res_found;
  logic [DAY_W-1:0]   res_day;
  logic [HOUR_W-1:0]  res_hour;
  logic [MIN_W-1:0]   res_min;

  // Decode of the incoming beat.
  assign accept   = in_valid && !in_stall;
  assign today_ok = (now_weekday < WDAY_W'(DAYS)) && day_mask[now_weekday] &&
                    (hour_index < HOUR_W'(HOURS));
  assign ahead_in = first_day(now_weekday, day_mask);
  assign ram_wen  = accept && (kind == KIND_LOAD) && (hour_index < HOUR_W'(HOURS));
  assign out_free = !out_valid || !out_stall;

  // Word read back, cleared if never loaded and masked below the start minute.
  assign word = ram_rdata & {MINUTES{rd_vld}} & (ALL_MIN << from_min);
  assign hit  = first_minute(word);

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (kind == KIND_QUERY && schedule_enabled && (today_ok || ahead_in.ok)) begin
            state_next = S_READ;
          end else begin
            state_next = S_PUT;
          end
        end
      end
      S_READ: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (hit.hit) begin
          state_next = S_PUT;
        end else if (cnt == LAST_HOUR && !(today_phase && ahead_ok)) begin
          state_next = S_PUT;
        end else begin
          state_next = S_READ;
        end
      end
      S_PUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State-driven outputs.
  always_comb begin
    in_stall = 1'b1;
    ram_ren  = 1'b0;
    out_load = 1'b0;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
      end
      S_READ: begin
        ram_ren = 1'b1;
      end
      S_EVAL: begin
      end
      S_PUT: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Valid bit per hour word; reset stands for an all-zero store.
  always_ff @(posedge clk) begin
    if (rst) begin
      hour_valid <= '0;
    end else if (ram_wen) begin
      hour_valid[hour_index] <= 1'b1;
    end
  end

  // Valid bit of the word being read, aligned with the RAM output.
  always_ff @(posedge clk) begin
    if (ram_ren) begin
      rd_vld <= hour_valid[cnt];
    end
  end

  // Search context and pending result.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept) begin
      res_found   <= 1'b0;
      res_day     <= '0;
      res_hour    <= '0;
      res_min     <= '0;
      cnt         <= today_ok ? hour_index : '0;
      from_min    <= today_ok ? now_minute : '0;
      today_phase <= today_ok;
      ahead_ok    <= ahead_in.ok;
      ahead_off   <= ahead_in.offset;
    end else if (state == S_EVAL) begin
      if (hit.hit) begin
        res_found <= 1'b1;
        res_day   <= today_phase ? '0 : ahead_off;
        res_hour  <= cnt;
        res_min   <= hit.minute;
      end else if (cnt == LAST_HOUR) begin
        // End of today: the days ahead all search the same hours from zero.
        cnt         <= '0;
        from_min    <= '0;
        today_phase <= 1'b0;
      end else begin
        cnt      <= HOUR_W'(cnt + HOUR_W'(1));
        from_min <= '0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      found        <= res_found;
      day_offset   <= res_day;
      start_hour   <= res_hour;
      start_minute <= res_min;
    end
  end

  // Hour word store.
  nsmf_ram #(
    .WIDTH (MINUTES),
    .DEPTH (HOURS)
  ) u_store (
    .clk   (clk),
    .wen   (ram_wen),
    .waddr (hour_index),
    .wdata (minute_bits),
    .ren   (ram_ren),
    .raddr (cnt),
    .rdata (ram_rdata)
  );

  // The read pointer stays inside the store.
  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    ram_ren |-> (cnt < HOUR_W'(HOURS)))
    else $error("store read beyond last hour");

  // Loads are only taken while no search is using the read port.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(ram_wen && ram_ren))
    else $error("store write during a search read");

  // A found start always names a real hour and minute.
  a_found_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found) |-> (start_hour < HOUR_W'(HOURS)) &&
                             (start_minute < MIN_W'(MINUTES)))
    else $error("found start outside the schedule");

  // A new result beat comes only from the result hand-off state.
  a_out_from_put: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_PUT))
    else $error("result beat raised outside hand-off");

  // Today's search never reports a later day.
  a_today_offset: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL && today_phase && hit.hit) |=> (res_day == '0))
    else $error("today hit with nonzero day offset");

endmodule
